FILE: hw/rtl/sma_pkg.sv
package sma_pkg;

    localparam int SMA_RING_DEPTH = 256;
    localparam int SMA_SAMPLE_BITS = 32;
    localparam int SMA_FIELD_BITS = 32;
    localparam int SMA_WINDOW_BITS = 9;
    localparam logic [SMA_WINDOW_BITS-1:0] SMA_WINDOW_RESET = 9'd20;

    typedef struct packed {
        logic signed [SMA_FIELD_BITS-1:0] sample_value;
        logic                             new_series;
    } sma_in_t;

    typedef struct packed {
        logic signed [SMA_FIELD_BITS-1:0] average_value;
    } sma_out_t;

    typedef logic [SMA_WINDOW_BITS-1:0] sma_cfg_t;

endpackage

FILE: hw/rtl/sma_stream_if.sv
interface sma_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

FILE: hw/rtl/sma_ram.sv
module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/sma_serial_div.sv
module sma_serial_div #(
    parameter int NUM_BITS = 40,
    parameter int DEN_BITS = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] dividend,
    input  logic [DEN_BITS-1:0] divisor,
    output logic                done,
    output logic [NUM_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   rem_shift;
    logic [DEN_BITS:0]   trial;

    // One quotient bit per cycle: shift the next dividend bit into the
    // partial remainder and subtract the divisor where it fits.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NUM_BITS-1]};
        trial     = rem_shift - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_BITS])
            begin
                rem_next = trial[DEN_BITS-1:0];
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DEN_BITS-1:0];
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/simple_moving_average.sv
// Simple moving average over signed Q16.16 samples. Each item carries one
// sample; once the configured window of samples has gathered since the last
// clear, every item yields one result item holding the window sum divided by
// the window length, truncated toward zero, and before that an item yields
// nothing. A new item is taken only once the last one is through; an item
// that yields a result waits on the restoring divider, which produces one
// quotient bit per cycle, and then on the output being free.
// The sample ring is a single memory with one write and one read port.
// A window length of zero acts as one and a length above the ring depth acts
// as the ring depth. Writing the window length, or an item with new_series
// set, restarts the window; the ring needs no clearing after reset.
module simple_moving_average #(
    parameter int RING_DEPTH  = sma_pkg::SMA_RING_DEPTH,
    parameter int SAMPLE_BITS = sma_pkg::SMA_SAMPLE_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    sma_stream_if.sink   sample_in,
    sma_stream_if.source average_out,
    sma_stream_if.sink   cfg
);

    localparam int PTR_BITS   = $clog2(RING_DEPTH);
    localparam int WIN_BITS   = $clog2(RING_DEPTH + 1);
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(RING_DEPTH);
    localparam int FIELD_BITS = sma_pkg::SMA_FIELD_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_START,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t                       state_reg, state_next;
    logic [sma_pkg::SMA_WINDOW_BITS-1:0] window_reg, window_next;
    logic [WIN_BITS-1:0]          fill_reg, fill_next;
    logic signed [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [PTR_BITS-1:0]          wp_reg, wp_next;
    logic [SAMPLE_BITS-1:0]       sample_reg, sample_next;
    logic                         series_reg, series_next;
    logic                         out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]       avg_reg, avg_next;

    logic                         in_accept;
    logic                         out_free;
    logic [SAMPLE_BITS-1:0]       sample_raw;
    logic [FIELD_BITS-1:0]        avg_port;
    logic [31:0]                  win_wide;
    logic [WIN_BITS-1:0]          eff_win;
    logic [WIN_BITS:0]            old_sum;
    logic [PTR_BITS-1:0]          old_addr;
    logic [SAMPLE_BITS-1:0]       old_sample;
    logic signed [SUM_BITS-1:0]   sample_ext;
    logic signed [SUM_BITS-1:0]   old_ext;
    logic signed [SUM_BITS-1:0]   base_sum;
    logic [WIN_BITS-1:0]          base_fill;
    logic                         win_full;
    logic                         ram_wr_en;
    logic                         div_start;
    logic [SUM_BITS-1:0]          div_dividend;
    logic                         div_done;
    logic [SUM_BITS-1:0]          div_quotient;
    logic [SUM_BITS-1:0]          signed_quotient;

    for (genvar i = 0; i < SAMPLE_BITS; i++)
    begin : g_in_bits
        if (i < FIELD_BITS)
        begin : g_take
            assign sample_raw[i] = sample_in.payload.sample_value[i];
        end
        else
        begin : g_zero
            assign sample_raw[i] = 1'b0;
        end
    end

    for (genvar i = 0; i < FIELD_BITS; i++)
    begin : g_out_bits
        if (i < SAMPLE_BITS)
        begin : g_take
            assign avg_port[i] = avg_reg[i];
        end
        else
        begin : g_zero
            assign avg_port[i] = 1'b0;
        end
    end

    assign in_accept       = sample_in.valid && sample_in.ready;
    assign sample_in.ready = (state_reg == ST_IDLE);
    assign cfg.ready       = 1'b1;
    assign out_free        = !out_valid_reg || average_out.ready;

    assign average_out.valid                 = out_valid_reg;
    assign average_out.payload.average_value = avg_port;

    always_comb
    begin
        win_wide = 32'(window_reg);
        if (win_wide == 32'd0)
        begin
            eff_win = WIN_BITS'(1);
        end
        else if (win_wide > 32'(RING_DEPTH))
        begin
            eff_win = WIN_BITS'(RING_DEPTH);
        end
        else
        begin
            eff_win = WIN_BITS'(window_reg);
        end
    end

    always_comb
    begin
        old_sum = {1'b0, WIN_BITS'(wp_reg)} + (WIN_BITS + 1)'(RING_DEPTH) - {1'b0, eff_win};
        if (old_sum >= (WIN_BITS + 1)'(RING_DEPTH))
        begin
            old_sum = old_sum - (WIN_BITS + 1)'(RING_DEPTH);
        end
        old_addr = PTR_BITS'(old_sum);
    end

    sma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (sample_reg),
        .rd_en   (in_accept),
        .rd_addr (old_addr),
        .rd_data (old_sample)
    );

    assign ram_wr_en    = (state_reg == ST_UPDATE);
    assign div_start    = (state_reg == ST_START);
    assign div_dividend = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);

    sma_serial_div #(
        .NUM_BITS (SUM_BITS),
        .DEN_BITS (WIN_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (eff_win),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign sample_ext = {{(SUM_BITS - SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg};
    assign old_ext    = {{(SUM_BITS - SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample};
    assign base_sum   = series_reg ? '0 : sum_reg;
    assign base_fill  = series_reg ? '0 : fill_reg;
    assign signed_quotient = sum_reg[SUM_BITS-1] ? (~div_quotient + 1'b1) : div_quotient;

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        wp_next        = wp_reg;
        sample_next    = sample_reg;
        series_next    = series_reg;
        out_valid_next = out_valid_reg;
        avg_next       = avg_reg;
        win_full       = 1'b0;

        if (out_valid_reg && average_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    sample_next = sample_raw;
                    series_next = sample_in.payload.new_series;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (base_fill >= eff_win)
                begin
                    sum_next  = base_sum - old_ext + sample_ext;
                    fill_next = eff_win;
                    win_full  = 1'b1;
                end
                else
                begin
                    sum_next  = base_sum + sample_ext;
                    fill_next = base_fill + 1'b1;
                    win_full  = (fill_next >= eff_win);
                end
                wp_next    = (wp_reg == PTR_BITS'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                state_next = win_full ? ST_START : ST_IDLE;
            end
            ST_START:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    avg_next       = SAMPLE_BITS'(signed_quotient);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg.valid && cfg.ready)
        begin
            window_next = cfg.payload;
            fill_next   = '0;
            sum_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= sma_pkg::SMA_WINDOW_RESET;
            fill_reg      <= '0;
            sum_reg       <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        series_reg <= series_next;
        avg_reg    <= avg_next;
    end

    // The window count never runs past the effective window length.
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= eff_win)
        else $error("fill count exceeds the window length");

    // The divider only finishes while the controller waits for it.
    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide state");

    // A result item appears only as the controller leaves the emit state.
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || average_out.ready) ##1 out_valid_reg |->
            $past(state_reg == ST_EMIT))
        else $error("result item raised outside the emit state");

endmodule
